[design/rhh_pkg.sv]
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared constants and types for the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhh_pkg;
  localparam int TableSlots = 256;
  localparam int ValueBits  = 32;
  localparam int SlotBits   = $clog2(TableSlots);
  localparam int DistBits   = SlotBits;
  localparam int CountBits  = SlotBits + 1;
  localparam int KeyBits    = 64;
  localparam int EntryBits  = KeyBits + ValueBits + DistBits;
  localparam logic [8:0] MaxEntriesReset = 9'd179;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO_KEY = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REFUSE
  } op_t;

  // classified request between front and back
  typedef struct packed {
    op_t                  op;
    logic [1:0]           status;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROBE,
    S_RESULT
  } state_t;
endpackage

[design/rhh_ram.sv]
// ----------------------------------------------------------------------------
// rhh_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[design/rhh_front.sv]
// ----------------------------------------------------------------------------
// rhh_front
// Accepts requests, refuses key zero, and holds a two-entry command queue.
// ----------------------------------------------------------------------------
module rhh_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [rhh_pkg::KeyBits-1:0]    key,
  input  logic [rhh_pkg::ValueBits-1:0]  value,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output rhh_pkg::cmd_t                  cmd
);
  rhh_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  rhh_pkg::cmd_t in_cmd;
  logic          push;
  logic          pop;

  always_comb begin
    in_cmd.key    = key;
    in_cmd.value  = value;
    in_cmd.status = rhh_pkg::ST_DONE;
    if (key == '0) begin
      in_cmd.op     = rhh_pkg::OP_REFUSE;
      in_cmd.status = rhh_pkg::ST_ZERO_KEY;
    end else if (req_type == rhh_pkg::REQ_LOOKUP) begin
      in_cmd.op = rhh_pkg::OP_LOOKUP;
    end else begin
      in_cmd.op = rhh_pkg::OP_INSERT;
    end
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 2'd1)
    else $error("queue fill did not advance");
`endif
endmodule

[design/rhh_back.sv]
// ----------------------------------------------------------------------------
// rhh_back
// Probe engine: walks the slot memory one slot at a time (S_READ, then
// S_PROBE), swapping on insert, and holds the result in an output register.
// ----------------------------------------------------------------------------
module rhh_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [8:0]                     max_entries,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  rhh_pkg::cmd_t                  cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [rhh_pkg::ValueBits-1:0]  found_value,
  output logic [1:0]                     status
);
  localparam int SB = rhh_pkg::SlotBits;
  localparam int DB = rhh_pkg::DistBits;
  localparam int KB = rhh_pkg::KeyBits;
  localparam int VB = rhh_pkg::ValueBits;
  localparam int CB = rhh_pkg::CountBits;

  rhh_pkg::state_t state, state_next;
  logic [rhh_pkg::TableSlots-1:0] valid_bits;
  logic [CB-1:0]  entry_count;
  rhh_pkg::op_t   op;
  logic [KB-1:0]  cur_key;
  logic [VB-1:0]  cur_value;
  logic [DB-1:0]  cur_dist;
  logic [SB-1:0]  pos;
  logic [CB-1:0]  steps;
  logic           slot_valid;
  logic [rhh_pkg::EntryBits-1:0] rd_entry;
  logic [rhh_pkg::EntryBits-1:0] wr_entry;
  logic           mem_we;
  logic [KB-1:0]  s_key;
  logic [VB-1:0]  s_value;
  logic [DB-1:0]  s_dist;
  logic           res_found;
  logic [VB-1:0]  res_value;
  logic [1:0]     res_status;
  logic           table_full;
  logic           finish;
  logic           take;

  assign {s_key, s_value, s_dist} = rd_entry;
  assign wr_entry = {cur_key, cur_value, cur_dist};
  assign table_full = (entry_count >= max_entries) ||
                      (entry_count >= CB'(rhh_pkg::TableSlots));

  rhh_ram #(.WIDTH(rhh_pkg::EntryBits), .DEPTH(rhh_pkg::TableSlots)) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .addr  (pos),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  assign take = cmd_valid && cmd_ready;

  // probe decision while in S_PROBE, using registered read data
  logic hit_empty, do_swap, key_hit, stop_miss;
  assign hit_empty = !slot_valid;
  assign do_swap   = slot_valid && (s_dist < cur_dist);
  assign key_hit   = slot_valid && !(s_dist < cur_dist) && (s_key == cur_key);
  assign stop_miss = hit_empty || (s_dist < cur_dist) || (steps == CB'(rhh_pkg::TableSlots));

  always_comb begin
    state_next = state;
    case (state)
      rhh_pkg::S_IDLE: if (take) state_next = (cmd.op == rhh_pkg::OP_REFUSE ||
                   (cmd.op == rhh_pkg::OP_INSERT && table_full)) ? rhh_pkg::S_RESULT
                   : rhh_pkg::S_READ;
      rhh_pkg::S_READ: state_next = rhh_pkg::S_PROBE;
      rhh_pkg::S_PROBE: begin
        if (op == rhh_pkg::OP_INSERT) begin
          state_next = hit_empty ? rhh_pkg::S_RESULT : rhh_pkg::S_READ;
        end else begin
          state_next = (key_hit || stop_miss) ? rhh_pkg::S_RESULT : rhh_pkg::S_READ;
        end
      end
      rhh_pkg::S_RESULT: if (out_ready) state_next = rhh_pkg::S_IDLE;
      default:  state_next = rhh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == rhh_pkg::S_IDLE);
    out_valid = (state == rhh_pkg::S_RESULT);
    mem_we    = (state == rhh_pkg::S_PROBE) && (op == rhh_pkg::OP_INSERT) &&
                (hit_empty || do_swap);
    finish    = (state == rhh_pkg::S_PROBE) && (state_next == rhh_pkg::S_RESULT);
  end

  assign found       = res_found;
  assign found_value = res_value;
  assign status      = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rhh_pkg::S_IDLE;
      valid_bits  <= '0;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (mem_we) valid_bits[pos] <= 1'b1;
      if (finish && op == rhh_pkg::OP_INSERT) entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rhh_pkg::S_IDLE: if (take) begin
        op         <= cmd.op;
        cur_key    <= cmd.key;
        cur_value  <= cmd.value;
        cur_dist   <= '0;
        pos        <= cmd.key[SB-1:0];
        steps      <= '0;
        res_found  <= 1'b0;
        res_value  <= '0;
        res_status <= (cmd.op == rhh_pkg::OP_INSERT && table_full) ? rhh_pkg::ST_FULL
                    : cmd.status;
      end
      rhh_pkg::S_READ: slot_valid <= valid_bits[pos];
      rhh_pkg::S_PROBE: begin
        if (op == rhh_pkg::OP_LOOKUP && key_hit) begin
          res_found <= 1'b1;
          res_value <= s_value;
        end
        if (do_swap && op == rhh_pkg::OP_INSERT) begin
          cur_key   <= s_key;
          cur_value <= s_value;
          cur_dist  <= s_dist + 1'b1;
        end else begin
          cur_dist <= cur_dist + 1'b1;
        end
        pos   <= pos + 1'b1;
        steps <= steps + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CB'(rhh_pkg::TableSlots))
    else $error("entry count overflow");
  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> op == rhh_pkg::OP_INSERT)
    else $error("slot write outside insert");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status))
    else $error("result dropped");
`endif
endmodule

[design/robin_hood_hash_table.sv]
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressed Robin Hood hash table, 256 slots, insert and lookup.
// ----------------------------------------------------------------------------
// A request passes through entry, then for each probed slot a memory read and
// then a compare with optional swap write on the single slot RAM port, then
// result; key-zero or table-full refusals go straight from entry to result.
// A two-entry queue at the input takes new transfers while the probe engine
// works. No clearing pass: slot valid bits reset at once.
module robin_hood_hash_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [8:0]                     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [rhh_pkg::KeyBits-1:0]    key,
  input  logic [rhh_pkg::ValueBits-1:0]  value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [rhh_pkg::ValueBits-1:0]  found_value,
  output logic [1:0]                     status
);
  logic          max_entries_we;
  logic [8:0]    max_entries;
  logic          cmd_valid;
  logic          cmd_ready;
  rhh_pkg::cmd_t cmd;

  assign max_entries_we = cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= rhh_pkg::MaxEntriesReset;
    end else if (max_entries_we) begin
      max_entries <= cfg_wdata;
    end
  end

  rhh_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key, .value,
    .cmd_valid, .cmd_ready, .cmd
  );

  rhh_back u_back (
    .clk, .rst, .max_entries, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .found, .found_value, .status
  );
endmodule
